### design/calendar_clock_counter_macros.svh
// Assertion helpers for the calendar clock counter.
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ccc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Wrap thresholds: a time counter above these rolls over; a month at or
  // above MONTH_LAST rolls into the next year.
  localparam logic [5:0]  SEC_LAST   = 6'd58;
  localparam logic [5:0]  MIN_LAST   = 6'd58;
  localparam logic [4:0]  HOUR_LAST  = 5'd22;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [15:0] DAYS_MAX   = 16'hFFFF;

  // Divisibility by 25 on 12-bit values: x * inverse (mod 4096) <= 4095 / 25.
  localparam logic [11:0] INV25      = 12'd3113;
  localparam logic [11:0] DIV25_MAX  = 12'd163;

  typedef struct packed {
    op_t         op;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] days_passed;
    logic        leap;
  } out_word_t;

  // Days in a month; callers only use it for months 1..12.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### design/ccc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ccc_in_if;
  import ccc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/ccc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ccc_out_if;
  import ccc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/ccc_leap.sv
`timescale 1ns / 1ps
`default_nettype none

module ccc_leap (
  input  wire logic [13:0] year,
  output logic             leap
);
  import ccc_pkg::*;

  logic [11:0] quarter;
  logic [11:0] prod;
  logic        div25;

  // Year divisible by 100 iff divisible by 4 and year/4 divisible by 25;
  // by 400 iff additionally divisible by 16.
  assign quarter = year[13:2];
  assign prod    = quarter * INV25;
  assign div25   = (prod <= DIV25_MAX);
  assign leap    = (year[1:0] == 2'b00) && (!div25 || (year[3:2] == 2'b00));

endmodule

`default_nettype wire

### design/ccc_advance.sv
`timescale 1ns / 1ps
`default_nettype none

module ccc_advance (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire ccc_pkg::in_word_t word,
  output ccc_pkg::out_word_t    state
);
  import ccc_pkg::*;

  logic [5:0]  sec, sec_next;
  logic [5:0]  min, min_next;
  logic [4:0]  hour, hour_next;
  logic [4:0]  day, day_next;
  logic [3:0]  month, month_next;
  logic [13:0] year, year_next;
  logic [15:0] days, days_next;
  logic        leap, leap_next;

  logic        sec_wrap, min_wrap, hour_wrap;
  logic        date_ok;
  logic [4:0]  mlen;
  logic [13:0] year_inc;
  logic [13:0] leap_year;
  logic        leap_res;

  assign sec_wrap  = (sec > SEC_LAST);
  assign min_wrap  = (min > MIN_LAST);
  assign hour_wrap = (hour > HOUR_LAST);
  assign date_ok   = (month != 4'd0) && (month <= MONTH_LAST);
  assign mlen      = month_len(month, leap);
  assign year_inc  = (year >= YEAR_MAX) ? YEAR_MAX : year + 14'd1;

  // One leap unit serves both the load and the year rollover.
  assign leap_year = (word.op == OP_LOAD) ? word.load_year : year_inc;

  ccc_leap u_leap (
    .year (leap_year),
    .leap (leap_res)
  );

  // Next clock and calendar state for one word.
  always_comb begin
    sec_next   = sec;
    min_next   = min;
    hour_next  = hour;
    day_next   = day;
    month_next = month;
    year_next  = year;
    days_next  = days;
    leap_next  = leap;
    if (word.op == OP_LOAD) begin
      sec_next   = word.load_second;
      min_next   = word.load_minute;
      hour_next  = word.load_hour;
      day_next   = word.load_day;
      month_next = word.load_month;
      year_next  = word.load_year;
      leap_next  = leap_res;
    end else if (!sec_wrap) begin
      sec_next = sec + 6'd1;
    end else begin
      sec_next = 6'd0;
      if (!min_wrap) begin
        min_next = min + 6'd1;
      end else begin
        min_next = 6'd0;
        if (!hour_wrap) begin
          hour_next = hour + 5'd1;
        end else begin
          // Midnight: count the day, then move the date if the month is sane.
          hour_next = 5'd0;
          if (days != DAYS_MAX) begin
            days_next = days + 16'd1;
          end
          if (date_ok) begin
            if (day >= mlen) begin
              day_next = 5'd1;
              if (month >= MONTH_LAST) begin
                month_next = 4'd1;
                year_next  = year_inc;
                leap_next  = leap_res;
              end else begin
                month_next = month + 4'd1;
              end
            end else begin
              day_next = day + 5'd1;
            end
          end
        end
      end
    end
  end

  // Hold state; it also serves as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec   <= '0;
      min   <= '0;
      hour  <= '0;
      day   <= '0;
      month <= '0;
      year  <= '0;
      days  <= '0;
      leap  <= 1'b0;
    end else if (fire) begin
      sec   <= sec_next;
      min   <= min_next;
      hour  <= hour_next;
      day   <= day_next;
      month <= month_next;
      year  <= year_next;
      days  <= days_next;
      leap  <= leap_next;
    end
  end

  assign state = '{second: sec, minute: min, hour: hour, day: day, month: month,
                   year: year, days_passed: days, leap: leap};

endmodule

`default_nettype wire

### design/calendar_clock_counter.sv
// Gregorian real-time clock calendar. Each input word is either a one-second
// tick or a load of time and date; each yields exactly one result word holding
// the full clock state after it. A word is taken into an input register,
// then, once the result slot is free or being taken, the carry chain
// (seconds, minutes, hours, day, month, saturating year and days-passed
// counters, leap rule) updates the state registers, which drive the result
// directly. The result is valid from that state update until it is taken.
// One word is accepted every cycle as long as results are taken, since a
// taken result frees the result slot in the same cycle; the combinational
// carry and leap path keeps that rate. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter (
  input  wire logic clk,
  input  wire logic rst,
  ccc_in_if.sink    item,
  ccc_out_if.source result
);
  import ccc_pkg::*;

  logic        in_valid;
  in_word_t    in_word;
  logic        out_valid;
  logic        fire;
  out_word_t   state;
  logic        bad_month_tick;
  logic [23:0] date_word;
  logic [15:0] days_cnt;

  // Advance when a word is held and the result slot is free or being taken.
  assign fire       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || fire;

  // Hold the accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_word <= item.data;
    end
  end

  ccc_advance u_advance (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .word  (in_word),
    .state (state)
  );

  // Flag the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = state;

  // Gather the terms the checks look at.
  assign bad_month_tick = fire && (in_word.op == OP_TICK) &&
                          ((state.month == 4'd0) || (state.month > MONTH_LAST));
  assign date_word      = {state.day, state.month, state.year, state.leap};
  assign days_cnt       = state.days_passed;

  `CCC_ASSERT_NEXT(a_hold_state, clk, rst, !fire, $stable(state), "state moved without a word")
  `CCC_ASSERT_NEXT(a_days_mono, clk, rst, 1'b1, days_cnt >= $past(days_cnt), "days went down")
  `CCC_ASSERT_NEXT(a_bad_month, clk, rst, bad_month_tick, $stable(date_word), "bad month moved")
  `CCC_ASSERT_NOW(a_no_drop, clk, rst, fire, !out_valid || result.ready, "result overwritten")

endmodule

`default_nettype wire
